FILE: design/assert_macros.svh
// Assertion macros shared by the spectrum block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define WSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that, once seen, forces another one at the next clock edge.
`define WSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/wsd_pkg.sv
// Package with the constants, state type and arithmetic helpers of the spectrum block.
`timescale 1ns / 1ps

package wsd_pkg;

    // Default sizes.
    localparam int DEF_MAX_SAMPLES = 1024;
    localparam int DEF_MAX_POINTS  = 64;
    localparam int DEF_VALUE_BITS  = 24;

    // APB address width: five registers at word spacing.
    localparam int APB_AW = 5;

    // Register indexes.
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_START  = 3'd1;
    localparam logic [2:0] REG_STEP   = 3'd2;
    localparam logic [2:0] REG_POINTS = 3'd3;
    localparam logic [2:0] REG_SPAN   = 3'd4;

    // Window modes.
    localparam logic [2:0] WIN_NONE     = 3'd0;
    localparam logic [2:0] WIN_RECT     = 3'd1;
    localparam logic [2:0] WIN_HANNING  = 3'd2;
    localparam logic [2:0] WIN_HAMMING  = 3'd3;
    localparam logic [2:0] WIN_TRIANGLE = 3'd4;
    localparam logic [2:0] WIN_BLACKMAN = 3'd5;

    // Fixed-point constants.
    localparam logic [16:0] Q16_ONE = 17'd65536;
    localparam int HAMM_K = 55827;
    localparam int BLK_K1 = 78019;
    localparam int BLK_K2 = 12483;
    localparam int SIN_A  = 102944;
    localparam int SIN_B  = 42047;
    localparam int SIN_C  = 4640;

    // The divider produces one quotient bit per cycle.
    localparam logic [6:0] DIV_STEPS = 7'd64;

    typedef enum logic [5:0] {
        S_LOAD, S_START, S_FEW,
        S_W_RD, S_W_CHK, S_W_DIV, S_W_SC, S_W_HAM, S_W_BK1, S_W_BK2, S_W_WR, S_W_ACC,
        S_M_GO, S_M_DIV,
        S_B_START, S_B_RD, S_B_V, S_B_Y, S_B_P1, S_B_P2, S_B_SC, S_B_MC, S_B_MS,
        S_BR_GO, S_BR_DIV, S_BI_GO, S_BI_DIV, S_OUT,
        S_SC0, S_SC1, S_SC2, S_SC3, S_SC4
    } state_t;

    // Product scaled by 2^-16, rounded toward zero.
    function automatic logic signed [53:0] trunc16(input logic signed [69:0] p);
        logic signed [69:0] adj;
        begin
            adj = p + (p[69] ? 70'sd65535 : 70'sd0);
            return 54'(adj >>> 16);
        end
    endfunction

    // Accumulation clamped at plus and minus two to the 60.
    function automatic logic signed [61:0] sat_add(input logic signed [61:0] a,
                                                   input logic signed [61:0] b);
        logic signed [62:0] r;
        logic signed [62:0] lim;
        begin
            lim = 63'sd1 <<< 60;
            r = 63'(a) + 63'(b);
            if (r > lim)
                r = lim;
            if (r < -lim)
                r = -lim;
            return 62'(r);
        end
    endfunction

    // Clamp to the signed 48-bit output range.
    function automatic logic signed [47:0] sat48(input logic signed [64:0] v);
        logic signed [64:0] hi;
        logic signed [64:0] lo;
        begin
            hi = (65'sd1 <<< 47) - 65'sd1;
            lo = -(65'sd1 <<< 47);
            if (v > hi)
                return 48'(hi);
            if (v < lo)
                return 48'(lo);
            return 48'(v);
        end
    endfunction

    // Magnitude of a signed 64-bit value.
    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        begin
            return v[63] ? 64'(-v) : 64'(v);
        end
    endfunction

endpackage

FILE: design/windowed_spectrum_dft.sv
// Windowed DFT spectrum of a time-stamped signal, built around one shared multiplier.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Samples load at one per cycle until the one marked last; the block then stalls its input
// while it runs. The run computes a window weight for each sample after the first: directly
// with no window or a rectangular one, by a bit-serial divide for the triangle, and by that
// divide plus one or two sine passes for the cosine windows. The windowed mean follows by a
// division. Each bin then makes a pass over the samples after the first and two scaling
// divisions; a DC bin takes its value straight from the mean. One 51 x 19 bit multiplier,
// registered, does every product, and one restoring divider does every division. With fewer
// than two samples one flagged result comes out and no run is made. Each result waits on
// bin_stall while the input stays stalled.
module windowed_spectrum_dft import wsd_pkg::*; #(
    parameter int MAX_SAMPLES = DEF_MAX_SAMPLES,
    parameter int MAX_POINTS  = DEF_MAX_POINTS,
    parameter int VALUE_BITS  = DEF_VALUE_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_AW-1:0]            paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         sample_valid,
    output logic                         sample_stall,
    input  logic [31:0]                  sample_time,
    input  logic signed [VALUE_BITS-1:0] sample_value,
    input  logic                         last_sample,
    output logic                         bin_valid,
    input  logic                         bin_stall,
    output logic [31:0]                  bin_frequency,
    output logic signed [47:0]           bin_real,
    output logic signed [47:0]           bin_imag,
    output logic                         too_few_samples,
    output logic                         last_bin
);

    localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);

    // Configuration registers.
    logic [2:0]  mode_reg;
    logic [31:0] start_reg;
    logic [31:0] step_reg;
    logic [6:0]  points_reg;
    logic [31:0] span_reg;

    // Sample, weight memories and their registered read data.
    logic [31:0]                  time_mem [MAX_SAMPLES];
    logic signed [VALUE_BITS-1:0] val_mem  [MAX_SAMPLES];
    logic [17:0]                  win_mem  [MAX_SAMPLES];
    logic [31:0]                  rd_time_reg;
    logic signed [VALUE_BITS-1:0] rd_val_reg;
    logic [17:0]                  rd_win_reg;
    logic                         load_we;
    logic                         win_we;

    // Sequencer state.
    state_t state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  k_inc;
    logic [31:0]       last_time_reg, last_time_next;
    logic [6:0]        j_reg, j_next;
    logic [6:0]        npts_reg, npts_next;
    logic [31:0]       fw_reg, fw_next;

    // Shared multiplier.
    logic signed [50:0] mul_a;
    logic signed [18:0] mul_b;
    logic signed [69:0] prod_reg;
    logic signed [53:0] prod_t16;

    // Shared divider.
    logic [63:0] div_q_reg, div_q_next;
    logic [31:0] div_rem_reg, div_rem_next;
    logic [31:0] div_den_reg, div_den_next;
    logic [6:0]  div_cnt_reg, div_cnt_next;
    logic        div_neg_reg, div_neg_next;
    logic [32:0] div_rem_sh;
    logic        div_ge;
    logic signed [64:0] div_res;

    // Sine and cosine sequencer.
    logic [31:0]        sc_phase_reg, sc_phase_next;
    logic               sc_side_reg, sc_side_next;
    logic               sc_bin_reg, sc_bin_next;
    logic               sc_second_reg, sc_second_next;
    logic [16:0]        sc_x2_reg, sc_x2_next;
    logic [16:0]        sc_a_reg, sc_a_next;
    logic signed [17:0] sc_s_reg, sc_s_next;
    logic signed [17:0] sc_c_reg, sc_c_next;
    logic signed [17:0] c1_reg, c1_next;
    logic [16:0]        sc_x;
    logic [16:0]        sc_xb;
    logic [16:0]        sc_t;
    logic [16:0]        sc_r;

    // Window, mean and bin datapath.
    logic [17:0]        w_reg, w_next;
    logic signed [19:0] bk_reg, bk_next;
    logic signed [61:0] acc_reg, acc_next;
    logic signed [61:0] ra_reg, ra_next;
    logic signed [61:0] ia_reg, ia_next;
    logic signed [47:0] mean_reg, mean_next;
    logic signed [50:0] y_reg, y_next;
    logic [31:0]        ph_lo_reg, ph_lo_next;
    logic signed [47:0] real_reg, real_next;
    logic signed [47:0] imag_reg, imag_next;

    logic        in_xfer;
    logic        out_xfer;
    logic        mode_plain;
    logic [31:0] span_eff;
    logic [31:0] delta_t;
    logic signed [19:0] tri_g;
    logic signed [19:0] tri_abs;
    logic signed [19:0] blk_sum;
    logic signed [47:0] v_now;
    logic        div_state;

    assign in_xfer  = sample_valid && !sample_stall;
    assign out_xfer = bin_valid && !bin_stall;
    assign pready   = 1'b1;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= WIN_HANNING;
            start_reg  <= '0;
            step_reg   <= 32'd1;
            points_reg <= 7'd64;
            span_reg   <= 32'd1;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[4:2])
                REG_MODE:   mode_reg   <= pwdata[2:0];
                REG_START:  start_reg  <= pwdata;
                REG_STEP:   step_reg   <= pwdata;
                REG_POINTS: points_reg <= pwdata[6:0];
                REG_SPAN:   span_reg   <= pwdata;
                default:    ;
            endcase
        end
    end

    // Register read-back.
    always_comb
    begin
        case (paddr[4:2])
            REG_MODE:   prdata = {29'd0, mode_reg};
            REG_START:  prdata = start_reg;
            REG_STEP:   prdata = step_reg;
            REG_POINTS: prdata = {25'd0, points_reg};
            REG_SPAN:   prdata = span_reg;
            default:    prdata = '0;
        endcase
    end

    // Memories: samples written while loading, weights during the window pass.
    assign load_we = in_xfer && (cnt_reg < CNT_W'(MAX_SAMPLES));

    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            time_mem[cnt_reg[ADDR_W-1:0]] <= sample_time;
            val_mem[cnt_reg[ADDR_W-1:0]]  <= sample_value;
        end
        if (win_we)
            win_mem[k_reg[ADDR_W-1:0]] <= w_reg;
        rd_time_reg <= time_mem[k_reg[ADDR_W-1:0]];
        rd_val_reg  <= val_mem[k_reg[ADDR_W-1:0]];
        rd_win_reg  <= win_mem[k_reg[ADDR_W-1:0]];
    end

    // Shared multiplier with registered product.
    always_ff @(posedge clk)
    begin
        prod_reg <= 70'(mul_a) * 70'(mul_b);
    end

    assign prod_t16 = trunc16(prod_reg);

    // One restoring-division step and the signed quotient.
    assign div_rem_sh = {div_rem_reg, div_q_reg[63]};
    assign div_ge     = div_rem_sh >= {1'b0, div_den_reg};
    assign div_res    = div_neg_reg ? -$signed({1'b0, div_q_reg}) : $signed({1'b0, div_q_reg});

    // Quarter-wave sine helpers.
    assign sc_x  = {1'b0, sc_phase_reg[29:14]};
    assign sc_xb = Q16_ONE - sc_x;
    assign sc_t  = 17'(SIN_B) - prod_reg[32:16];
    assign sc_r  = (prod_reg[33:16] > 18'(Q16_ONE)) ? Q16_ONE : prod_reg[32:16];

    // Window helpers.
    assign mode_plain = (mode_reg == WIN_NONE) || (mode_reg > WIN_BLACKMAN);
    assign span_eff   = (span_reg == 32'd0) ? 32'd1 : span_reg;
    assign delta_t    = last_time_reg - rd_time_reg;
    assign tri_g      = 20'sd131072 - $signed({1'b0, div_q_reg[32:14]});
    assign tri_abs    = tri_g[19] ? -tri_g : tri_g;
    assign blk_sum    = bk_reg + 20'(prod_t16);
    assign v_now      = sat48((65'($signed(rd_val_reg)) <<< 16) - 65'(mean_reg));
    assign k_inc      = k_reg + CNT_W'(1);

    // State and datapath registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_LOAD;
            cnt_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        k_reg         <= k_next;
        last_time_reg <= last_time_next;
        j_reg         <= j_next;
        npts_reg      <= npts_next;
        fw_reg        <= fw_next;
        div_q_reg     <= div_q_next;
        div_rem_reg   <= div_rem_next;
        div_den_reg   <= div_den_next;
        div_neg_reg   <= div_neg_next;
        sc_phase_reg  <= sc_phase_next;
        sc_side_reg   <= sc_side_next;
        sc_bin_reg    <= sc_bin_next;
        sc_second_reg <= sc_second_next;
        sc_x2_reg     <= sc_x2_next;
        sc_a_reg      <= sc_a_next;
        sc_s_reg      <= sc_s_next;
        sc_c_reg      <= sc_c_next;
        c1_reg        <= c1_next;
        w_reg         <= w_next;
        bk_reg        <= bk_next;
        acc_reg       <= acc_next;
        ra_reg        <= ra_next;
        ia_reg        <= ia_next;
        mean_reg      <= mean_next;
        y_reg         <= y_next;
        ph_lo_reg     <= ph_lo_next;
        real_reg      <= real_next;
        imag_reg      <= imag_next;
    end

    // Sequencer: next state, multiplier operands and datapath updates.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        last_time_next = last_time_reg;
        j_next         = j_reg;
        npts_next      = npts_reg;
        fw_next        = fw_reg;
        div_q_next     = div_q_reg;
        div_rem_next   = div_rem_reg;
        div_den_next   = div_den_reg;
        div_cnt_next   = div_cnt_reg;
        div_neg_next   = div_neg_reg;
        sc_phase_next  = sc_phase_reg;
        sc_side_next   = sc_side_reg;
        sc_bin_next    = sc_bin_reg;
        sc_second_next = sc_second_reg;
        sc_x2_next     = sc_x2_reg;
        sc_a_next      = sc_a_reg;
        sc_s_next      = sc_s_reg;
        sc_c_next      = sc_c_reg;
        c1_next        = c1_reg;
        w_next         = w_reg;
        bk_next        = bk_reg;
        acc_next       = acc_reg;
        ra_next        = ra_reg;
        ia_next        = ia_reg;
        mean_next      = mean_reg;
        y_next         = y_reg;
        ph_lo_next     = ph_lo_reg;
        real_next      = real_reg;
        imag_next      = imag_reg;
        mul_a          = '0;
        mul_b          = '0;
        win_we         = 1'b0;
        sample_stall   = 1'b1;
        bin_valid      = 1'b0;

        // The divider steps on its own whenever it has bits left.
        if (div_cnt_reg != 7'd0)
        begin
            div_rem_next = div_ge ? 32'(div_rem_sh - {1'b0, div_den_reg}) : div_rem_sh[31:0];
            div_q_next   = {div_q_reg[62:0], div_ge};
            div_cnt_next = div_cnt_reg - 7'd1;
        end

        unique case (state_reg)
            // Take samples until the marked one.
            S_LOAD:
            begin
                sample_stall = 1'b0;
                if (in_xfer)
                begin
                    if (load_we)
                    begin
                        cnt_next       = cnt_reg + CNT_W'(1);
                        last_time_next = sample_time;
                    end
                    if (last_sample)
                    begin
                        n_next     = load_we ? cnt_reg + CNT_W'(1) : cnt_reg;
                        cnt_next   = '0;
                        state_next = S_START;
                    end
                end
            end

            S_START:
            begin
                if (n_reg < CNT_W'(2))
                    state_next = S_FEW;
                else
                begin
                    k_next     = CNT_W'(1);
                    acc_next   = '0;
                    state_next = S_W_RD;
                end
                if (points_reg == 7'd0)
                    npts_next = 7'd1;
                else if (points_reg > 7'(MAX_POINTS))
                    npts_next = 7'(MAX_POINTS);
                else
                    npts_next = points_reg;
            end

            S_FEW:
            begin
                bin_valid = 1'b1;
                if (!bin_stall)
                    state_next = S_LOAD;
            end

            // Window weight of sample k.
            S_W_RD:
                state_next = S_W_CHK;

            S_W_CHK:
            begin
                if (mode_plain)
                begin
                    w_next     = 18'(Q16_ONE);
                    state_next = S_W_WR;
                end
                else if (delta_t > span_eff)
                begin
                    w_next     = '0;
                    state_next = S_W_WR;
                end
                else if (mode_reg == WIN_RECT)
                begin
                    w_next     = 18'(Q16_ONE);
                    state_next = S_W_WR;
                end
                else
                begin
                    div_q_next   = {delta_t, 32'd0};
                    div_rem_next = '0;
                    div_den_next = span_eff;
                    div_neg_next = 1'b0;
                    div_cnt_next = DIV_STEPS;
                    state_next   = S_W_DIV;
                end
            end

            S_W_DIV:
            begin
                if (div_cnt_reg == 7'd0)
                begin
                    if (mode_reg == WIN_TRIANGLE)
                    begin
                        w_next     = 18'(20'sd131072 - tri_abs);
                        state_next = S_W_WR;
                    end
                    else
                    begin
                        sc_phase_next  = div_q_reg[31:0];
                        sc_side_next   = 1'b0;
                        sc_bin_next    = 1'b0;
                        sc_second_next = 1'b0;
                        state_next     = S_SC0;
                    end
                end
            end

            S_W_SC:
            begin
                if (mode_reg == WIN_HANNING)
                begin
                    w_next     = 18'($signed({2'b0, Q16_ONE}) - 19'(sc_c_reg));
                    state_next = S_W_WR;
                end
                else if (mode_reg == WIN_HAMMING)
                begin
                    mul_a      = 51'(HAMM_K);
                    mul_b      = 19'(sc_c_reg);
                    state_next = S_W_HAM;
                end
                else if (!sc_second_reg)
                begin
                    c1_next        = sc_c_reg;
                    sc_phase_next  = {div_q_reg[30:0], 1'b0};
                    sc_side_next   = 1'b0;
                    sc_second_next = 1'b1;
                    state_next     = S_SC0;
                end
                else
                begin
                    mul_a      = 51'(BLK_K1);
                    mul_b      = 19'(c1_reg);
                    state_next = S_W_BK1;
                end
            end

            S_W_HAM:
            begin
                w_next     = 18'($signed({3'b0, Q16_ONE}) - 20'(prod_t16));
                state_next = S_W_WR;
            end

            S_W_BK1:
            begin
                bk_next    = $signed({3'b0, Q16_ONE}) - 20'(prod_t16);
                mul_a      = 51'(BLK_K2);
                mul_b      = 19'(sc_c_reg);
                state_next = S_W_BK2;
            end

            S_W_BK2:
            begin
                w_next     = blk_sum[19] ? 18'd0 : blk_sum[17:0];
                state_next = S_W_WR;
            end

            // Store the weight and accumulate the weighted sample.
            S_W_WR:
            begin
                win_we     = 1'b1;
                mul_a      = 51'(rd_val_reg);
                mul_b      = $signed({1'b0, w_reg});
                state_next = S_W_ACC;
            end

            S_W_ACC:
            begin
                acc_next = sat_add(acc_reg, 62'(prod_reg));
                k_next   = k_inc;
                if (k_inc == n_reg)
                    state_next = S_M_GO;
                else
                    state_next = S_W_RD;
            end

            // Windowed mean.
            S_M_GO:
            begin
                div_q_next   = mag64(64'(acc_reg));
                div_rem_next = '0;
                div_den_next = 32'(n_reg - CNT_W'(1));
                div_neg_next = acc_reg[61];
                div_cnt_next = DIV_STEPS;
                state_next   = S_M_DIV;
            end

            S_M_DIV:
            begin
                if (div_cnt_reg == 7'd0)
                begin
                    mean_next  = sat48(div_res);
                    j_next     = '0;
                    fw_next    = start_reg;
                    state_next = S_B_START;
                end
            end

            // One bin: direct value for DC, otherwise a pass over the samples.
            S_B_START:
            begin
                if ((j_reg == 7'd0) && (start_reg == 32'd0))
                begin
                    real_next  = mean_reg;
                    imag_next  = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    k_next     = CNT_W'(1);
                    ra_next    = '0;
                    ia_next    = '0;
                    state_next = S_B_RD;
                end
            end

            S_B_RD:
                state_next = S_B_V;

            S_B_V:
            begin
                mul_a      = 51'(v_now);
                mul_b      = $signed({1'b0, rd_win_reg});
                state_next = S_B_Y;
            end

            S_B_Y:
            begin
                y_next     = 51'(prod_t16);
                mul_a      = $signed({19'd0, rd_time_reg});
                mul_b      = $signed({3'd0, fw_reg[15:0]});
                state_next = S_B_P1;
            end

            S_B_P1:
            begin
                ph_lo_next = prod_reg[31:0];
                mul_a      = $signed({19'd0, rd_time_reg});
                mul_b      = $signed({3'd0, fw_reg[31:16]});
                state_next = S_B_P2;
            end

            S_B_P2:
            begin
                sc_phase_next = ph_lo_reg + {prod_reg[15:0], 16'd0};
                sc_side_next  = 1'b0;
                sc_bin_next   = 1'b1;
                state_next    = S_SC0;
            end

            S_B_SC:
            begin
                mul_a      = y_reg;
                mul_b      = 19'(sc_c_reg);
                state_next = S_B_MC;
            end

            S_B_MC:
            begin
                ra_next    = sat_add(ra_reg, 62'(prod_t16));
                mul_a      = y_reg;
                mul_b      = 19'(sc_s_reg);
                state_next = S_B_MS;
            end

            S_B_MS:
            begin
                ia_next = sat_add(ia_reg, 62'(prod_t16));
                k_next  = k_inc;
                if (k_inc == n_reg)
                    state_next = S_BR_GO;
                else
                    state_next = S_B_RD;
            end

            // Scale both sums by two over n minus one.
            S_BR_GO:
            begin
                div_q_next   = mag64(64'(ra_reg) <<< 1);
                div_rem_next = '0;
                div_den_next = 32'(n_reg - CNT_W'(1));
                div_neg_next = ra_reg[61];
                div_cnt_next = DIV_STEPS;
                state_next   = S_BR_DIV;
            end

            S_BR_DIV:
            begin
                if (div_cnt_reg == 7'd0)
                begin
                    real_next  = sat48(div_res);
                    state_next = S_BI_GO;
                end
            end

            S_BI_GO:
            begin
                div_q_next   = mag64(64'(ia_reg) <<< 1);
                div_rem_next = '0;
                div_den_next = 32'(n_reg - CNT_W'(1));
                div_neg_next = ia_reg[61];
                div_cnt_next = DIV_STEPS;
                state_next   = S_BI_DIV;
            end

            S_BI_DIV:
            begin
                if (div_cnt_reg == 7'd0)
                begin
                    imag_next  = sat48(div_res);
                    state_next = S_OUT;
                end
            end

            // Hold the bin until it is transferred.
            S_OUT:
            begin
                bin_valid = 1'b1;
                if (!bin_stall)
                begin
                    if (j_reg + 7'd1 == npts_reg)
                        state_next = S_LOAD;
                    else
                    begin
                        j_next     = j_reg + 7'd1;
                        fw_next    = fw_reg + step_reg;
                        state_next = S_B_START;
                    end
                end
            end

            // Quarter sine of x, then of one minus x, then the quadrant mapping.
            S_SC0:
            begin
                mul_a      = $signed({34'd0, sc_x});
                mul_b      = $signed({2'd0, sc_x});
                state_next = S_SC1;
            end

            S_SC1:
            begin
                sc_x2_next = prod_reg[32:16];
                mul_a      = 51'(SIN_C);
                mul_b      = $signed({2'd0, prod_reg[32:16]});
                state_next = S_SC2;
            end

            S_SC2:
            begin
                mul_a      = $signed({34'd0, sc_t});
                mul_b      = $signed({2'd0, sc_x2_reg});
                state_next = S_SC3;
            end

            S_SC3:
            begin
                mul_a      = 51'(SIN_A) - $signed({34'd0, prod_reg[32:16]});
                mul_b      = $signed({2'd0, sc_side_reg ? sc_xb : sc_x});
                state_next = S_SC4;
            end

            S_SC4:
            begin
                if (!sc_side_reg)
                begin
                    sc_a_next    = sc_r;
                    sc_side_next = 1'b1;
                    mul_a        = $signed({34'd0, sc_xb});
                    mul_b        = $signed({2'd0, sc_xb});
                    state_next   = S_SC1;
                end
                else
                begin
                    unique case (sc_phase_reg[31:30])
                        2'd0:
                        begin
                            sc_s_next = $signed({1'b0, sc_a_reg});
                            sc_c_next = $signed({1'b0, sc_r});
                        end
                        2'd1:
                        begin
                            sc_s_next = $signed({1'b0, sc_r});
                            sc_c_next = -$signed({1'b0, sc_a_reg});
                        end
                        2'd2:
                        begin
                            sc_s_next = -$signed({1'b0, sc_a_reg});
                            sc_c_next = -$signed({1'b0, sc_r});
                        end
                        default:
                        begin
                            sc_s_next = -$signed({1'b0, sc_r});
                            sc_c_next = $signed({1'b0, sc_a_reg});
                        end
                    endcase
                    state_next = sc_bin_reg ? S_B_SC : S_W_SC;
                end
            end

            default:
                state_next = S_LOAD;
        endcase
    end

    // Result ports.
    assign too_few_samples = (state_reg == S_FEW);
    assign bin_frequency   = too_few_samples ? 32'd0 : fw_reg;
    assign bin_real        = too_few_samples ? 48'sd0 : real_reg;
    assign bin_imag        = too_few_samples ? 48'sd0 : imag_reg;
    assign last_bin        = too_few_samples || (j_reg + 7'd1 == npts_reg);

    // States in which the divider may be stepping.
    assign div_state = (state_reg == S_W_DIV) || (state_reg == S_M_DIV) ||
                       (state_reg == S_BR_DIV) || (state_reg == S_BI_DIV);

    // Checks on the sequencer.
    `WSD_ASSERT(a_one_side, !(bin_valid && !sample_stall), "input open while a bin is shown")
    `WSD_ASSERT(a_cnt_bound, cnt_reg <= CNT_W'(MAX_SAMPLES), "sample count beyond the store")
    `WSD_ASSERT(a_div_owner, (div_cnt_reg == 7'd0) || div_state, "divider busy out of turn")
    `WSD_ASSERT_NEXT(a_run_end, out_xfer && last_bin, !sample_stall, "no loading after run")

endmodule
